// ----- rtl/sla_pkg.sv -----
// shared widths, register indexes and reset values for the spotlight attenuation block
package sla_pkg;
  localparam int CoordW = 32;
  localparam int DirW = 18;
  localparam int CosW = 18;
  localparam int DistW = 32;
  localparam int AttW = 32;
  localparam int IdxW = 4;
  localparam int CfgDataW = 32;
  localparam int CoordFracBitsDef = 16;
  localparam int DirOneShift = 16;

  localparam int DW = CoordW + 1;
  localparam int MW = CoordW + 1;
  localparam int SW = 2 * MW;
  localparam int RW = SW / 2;
  localparam int ProdW = DW + CosW;
  localparam int DotW = ProdW + 2;
  localparam int DotMW = DotW - 1;
  localparam int DirQW = 20;
  localparam int FoW = DirOneShift + 1;
  localparam int CW = DirQW + 1;
  localparam int FDenW = CosW + 1;
  localparam int FNumW = FDenW + DirOneShift + 1;

  localparam logic signed [CoordW-1:0] LightRst = '0;
  localparam logic signed [CosW-1:0] AxisXRst = 18'sd0;
  localparam logic signed [CosW-1:0] AxisYRst = 18'sd0;
  localparam logic signed [CosW-1:0] AxisZRst = 18'sd65536;
  localparam logic signed [CosW-1:0] InnerCosRst = 18'sd58982;
  localparam logic signed [CosW-1:0] OuterCosRst = 18'sd52429;

  typedef enum logic [IdxW-1:0] {
    REG_LIGHT_X   = 4'd0,
    REG_LIGHT_Y   = 4'd1,
    REG_LIGHT_Z   = 4'd2,
    REG_AXIS_X    = 4'd3,
    REG_AXIS_Y    = 4'd4,
    REG_AXIS_Z    = 4'd5,
    REG_INNER_COS = 4'd6,
    REG_OUTER_COS = 4'd7
  } cfg_reg_t;
endpackage

// ----- rtl/sla_if.sv -----
// channel interfaces for points, results and register writes
interface sla_in_if import sla_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sla_out_if import sla_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DirW-1:0] to_light_x;
  logic signed [DirW-1:0] to_light_y;
  logic signed [DirW-1:0] to_light_z;
  logic [DistW-1:0] light_distance;
  logic [AttW-1:0] attenuation;
  logic degenerate;
  modport source (output valid, to_light_x, to_light_y, to_light_z, light_distance,
                  attenuation, degenerate, input ready);
  modport sink (input valid, to_light_x, to_light_y, to_light_z, light_distance,
                attenuation, degenerate, output ready);
endinterface

interface sla_cfg_if import sla_pkg::*; ();
  logic valid;
  logic ready;
  logic [IdxW-1:0] index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/sla_sqrt.sv -----
// pipelined integer square root, one root bit per stage, with side payload
module sla_sqrt #(
  parameter int S_W = 66,
  parameter int PAY_W = 1,
  localparam int R_W = S_W / 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [S_W-1:0]   sq,
  input  logic [PAY_W-1:0] pay,
  output logic             out_valid,
  output logic [R_W-1:0]   root,
  output logic [PAY_W-1:0] out_pay
);
  localparam int TW = S_W + 1;

  logic             v_r [R_W];
  logic [S_W-1:0]   rem_r [R_W];
  logic [R_W-1:0]   root_r [R_W];
  logic [PAY_W-1:0] pay_r [R_W];

  logic             v_in [R_W];
  logic [S_W-1:0]   rem_in [R_W];
  logic [R_W-1:0]   root_in [R_W];
  logic [PAY_W-1:0] pay_in [R_W];
  logic [S_W-1:0]   rem_nxt [R_W];
  logic [R_W-1:0]   root_nxt [R_W];

  always_comb begin
    v_in[0] = in_valid;
    rem_in[0] = sq;
    root_in[0] = '0;
    pay_in[0] = pay;
    for (int j = 1; j < R_W; j++) begin
      v_in[j] = v_r[j-1];
      rem_in[j] = rem_r[j-1];
      root_in[j] = root_r[j-1];
      pay_in[j] = pay_r[j-1];
    end
  end

  always_comb begin
    logic [TW-1:0] t;
    t = '0;
    for (int j = 0; j < R_W; j++) begin
      t = (TW'(root_in[j]) << (R_W - j)) + (TW'(1) << (2 * (R_W - 1 - j)));
      if (TW'(rem_in[j]) >= t) begin
        rem_nxt[j] = rem_in[j] - S_W'(t);
        root_nxt[j] = root_in[j] | (R_W'(1) << (R_W - 1 - j));
      end else begin
        rem_nxt[j] = rem_in[j];
        root_nxt[j] = root_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < R_W; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < R_W; j++) v_r[j] <= v_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < R_W; j++) begin
        rem_r[j] <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        pay_r[j] <= pay_in[j];
      end
    end
  end

  assign out_valid = v_r[R_W-1];
  assign root = root_r[R_W-1];
  assign out_pay = pay_r[R_W-1];
endmodule

// ----- rtl/sla_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with side payload
module sla_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int Q_W = 4,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] pay,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot,
  output logic [PAY_W-1:0] out_pay
);
  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             v_r [Q_W];
  logic [CW-1:0]    rem_r [Q_W];
  logic [Q_W-1:0]   q_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [PAY_W-1:0] pay_r [Q_W];

  logic             v_in [Q_W];
  logic [CW-1:0]    rem_in [Q_W];
  logic [Q_W-1:0]   q_in [Q_W];
  logic [DEN_W-1:0] den_in [Q_W];
  logic [PAY_W-1:0] pay_in [Q_W];
  logic [CW-1:0]    rem_nxt [Q_W];
  logic [Q_W-1:0]   q_nxt [Q_W];

  always_comb begin
    v_in[0] = in_valid;
    rem_in[0] = CW'(num);
    q_in[0] = '0;
    den_in[0] = den;
    pay_in[0] = pay;
    for (int j = 1; j < Q_W; j++) begin
      v_in[j] = v_r[j-1];
      rem_in[j] = rem_r[j-1];
      q_in[j] = q_r[j-1];
      den_in[j] = den_r[j-1];
      pay_in[j] = pay_r[j-1];
    end
  end

  always_comb begin
    logic [CW-1:0] dsh;
    dsh = '0;
    for (int j = 0; j < Q_W; j++) begin
      dsh = CW'(den_in[j]) << (Q_W - 1 - j);
      if (rem_in[j] >= dsh) begin
        rem_nxt[j] = rem_in[j] - dsh;
        q_nxt[j] = q_in[j] | (Q_W'(1) << (Q_W - 1 - j));
      end else begin
        rem_nxt[j] = rem_in[j];
        q_nxt[j] = q_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < Q_W; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < Q_W; j++) v_r[j] <= v_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < Q_W; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j] <= q_nxt[j];
        den_r[j] <= den_in[j];
        pay_r[j] <= pay_in[j];
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign quot = q_r[Q_W-1];
  assign out_pay = pay_r[Q_W-1];
endmodule

// ----- rtl/spot_light_attenuation.sv -----
// spotlight cone falloff and inverse-square attenuation, top level
// throughput: one word per cycle unless stalled
// square root and six dividers are bit-per-stage pipelines
// a full pipeline stalls as a whole only while the result word waits and the entry stage is full
// reset: synchronous active-low rst_n clears valid bits and loads register defaults
module spot_light_attenuation import sla_pkg::*; #(
  parameter int COORD_FRAC_BITS = CoordFracBitsDef
) (
  input logic clk,
  input logic rst_n,
  sla_in_if.sink    in_ch,
  sla_out_if.source out_ch,
  sla_cfg_if.sink   cfg_ch
);
  localparam int Sh = 3 * COORD_FRAC_BITS - DirOneShift;
  localparam int AtNW = FoW + Sh;
  localparam int CmpW = (AtNW > SW + AttW) ? AtNW : SW + AttW;
  localparam int TlNW = MW + DirOneShift + 1;
  localparam int CmNW = DotMW + 1;
  localparam int SqPW = 3 * MW + DotW + SW + 4;
  localparam int CmPW = RW + SW + 2;
  localparam int DlPW = 3 * DirW + DistW + SW + 3;
  localparam int AtPW = 3 * DirW + DistW + 2;

  // configuration registers
  logic signed [CoordW-1:0] light_x_r, light_y_r, light_z_r;
  logic signed [CosW-1:0] axis_x_r, axis_y_r, axis_z_r, inner_cos_r, outer_cos_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= LightRst;
      light_y_r <= LightRst;
      light_z_r <= LightRst;
      axis_x_r <= AxisXRst;
      axis_y_r <= AxisYRst;
      axis_z_r <= AxisZRst;
      inner_cos_r <= InnerCosRst;
      outer_cos_r <= OuterCosRst;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_LIGHT_X:   light_x_r <= cfg_ch.data[CoordW-1:0];
        REG_LIGHT_Y:   light_y_r <= cfg_ch.data[CoordW-1:0];
        REG_LIGHT_Z:   light_z_r <= cfg_ch.data[CoordW-1:0];
        REG_AXIS_X:    axis_x_r <= cfg_ch.data[CosW-1:0];
        REG_AXIS_Y:    axis_y_r <= cfg_ch.data[CosW-1:0];
        REG_AXIS_Z:    axis_z_r <= cfg_ch.data[CosW-1:0];
        REG_INNER_COS: inner_cos_r <= cfg_ch.data[CosW-1:0];
        REG_OUTER_COS: outer_cos_r <= cfg_ch.data[CosW-1:0];
        default: ;
      endcase
    end
  end

  logic en, ld1;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;

  // stage 1: difference vector
  logic v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dz1_r;
  assign ld1 = en || !v1_r;
  assign in_ch.ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (ld1) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dx1_r <= DW'(light_x_r) - DW'(in_ch.point_x);
      dy1_r <= DW'(light_y_r) - DW'(in_ch.point_y);
      dz1_r <= DW'(light_z_r) - DW'(in_ch.point_z);
    end
  end

  // stage 2: magnitudes, squares, axis products
  logic v2_r, deg2_r, sx2_r, sy2_r, sz2_r;
  logic [MW-1:0] mx2_r, my2_r, mz2_r;
  logic [SW-1:0] qx2_r, qy2_r, qz2_r;
  logic signed [ProdW-1:0] px2_r, py2_r, pz2_r;
  logic [MW-1:0] mx_nxt, my_nxt, mz_nxt;

  always_comb begin
    mx_nxt = dx1_r[DW-1] ? MW'(-dx1_r) : MW'(dx1_r);
    my_nxt = dy1_r[DW-1] ? MW'(-dy1_r) : MW'(dy1_r);
    mz_nxt = dz1_r[DW-1] ? MW'(-dz1_r) : MW'(dz1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg2_r <= (dx1_r == '0) && (dy1_r == '0) && (dz1_r == '0);
      sx2_r <= dx1_r[DW-1];
      sy2_r <= dy1_r[DW-1];
      sz2_r <= dz1_r[DW-1];
      mx2_r <= mx_nxt;
      my2_r <= my_nxt;
      mz2_r <= mz_nxt;
      qx2_r <= SW'(mx_nxt) * SW'(mx_nxt);
      qy2_r <= SW'(my_nxt) * SW'(my_nxt);
      qz2_r <= SW'(mz_nxt) * SW'(mz_nxt);
      px2_r <= ProdW'(dx1_r) * ProdW'(axis_x_r);
      py2_r <= ProdW'(dy1_r) * ProdW'(axis_y_r);
      pz2_r <= ProdW'(dz1_r) * ProdW'(axis_z_r);
    end
  end

  // stage 3: squared length and dot product
  logic v3_r, deg3_r, sx3_r, sy3_r, sz3_r;
  logic [MW-1:0] mx3_r, my3_r, mz3_r;
  logic [SW-1:0] s3_r;
  logic signed [DotW-1:0] dot3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg3_r <= deg2_r;
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      sz3_r <= sz2_r;
      mx3_r <= mx2_r;
      my3_r <= my2_r;
      mz3_r <= mz2_r;
      s3_r <= qx2_r + qy2_r + qz2_r;
      dot3_r <= DotW'(px2_r) + DotW'(py2_r) + DotW'(pz2_r);
    end
  end

  // square root
  logic sq_v;
  logic [RW-1:0] dist_raw;
  logic [SqPW-1:0] sq_pay;
  logic [MW-1:0] u_mx, u_my, u_mz;
  logic signed [DotW-1:0] u_dot;
  logic [SW-1:0] u_s;
  logic u_sx, u_sy, u_sz, u_deg;

  sla_sqrt #(.S_W(SW), .PAY_W(SqPW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_r), .sq(s3_r),
    .pay({mx3_r, my3_r, mz3_r, dot3_r, s3_r, sx3_r, sy3_r, sz3_r, deg3_r}),
    .out_valid(sq_v), .root(dist_raw), .out_pay(sq_pay)
  );

  assign {u_mx, u_my, u_mz, u_dot, u_s, u_sx, u_sy, u_sz, u_deg} = sq_pay;

  // stage 4: rounded numerators for the direction and cosine divisions
  logic v4_r, sx4_r, sy4_r, sz4_r, deg4_r, dneg4_r;
  logic [TlNW-1:0] nx4_r, ny4_r, nz4_r;
  logic [CmNW-1:0] ncm4_r;
  logic [RW-1:0] dist4_r;
  logic [SW-1:0] s4_r;
  logic [DotMW-1:0] dotm_nxt;

  assign dotm_nxt = u_dot[DotW-1] ? DotMW'(-u_dot) : DotMW'(u_dot);

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= sq_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx4_r <= TlNW'({u_mx, {DirOneShift{1'b0}}}) + TlNW'(dist_raw >> 1);
      ny4_r <= TlNW'({u_my, {DirOneShift{1'b0}}}) + TlNW'(dist_raw >> 1);
      nz4_r <= TlNW'({u_mz, {DirOneShift{1'b0}}}) + TlNW'(dist_raw >> 1);
      ncm4_r <= CmNW'(dotm_nxt) + CmNW'(dist_raw >> 1);
      dist4_r <= dist_raw;
      s4_r <= u_s;
      sx4_r <= u_sx;
      sy4_r <= u_sy;
      sz4_r <= u_sz;
      deg4_r <= u_deg;
      dneg4_r <= u_dot[DotW-1];
    end
  end

  // direction and cosine dividers
  logic tlx_v, tly_v, tlz_v, cm_v;
  logic [DirQW-1:0] tlx_q, tly_q, tlz_q, cm_q;
  logic tlx_s, tly_s, tlz_s;
  logic [CmPW-1:0] cm_pay;
  logic [RW-1:0] c_dist;
  logic [SW-1:0] c_s;
  logic c_deg, c_dneg;

  sla_div #(.NUM_W(TlNW), .DEN_W(RW), .Q_W(DirQW), .PAY_W(1)) u_div_tlx (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .num(nx4_r), .den(dist4_r),
    .pay(sx4_r), .out_valid(tlx_v), .quot(tlx_q), .out_pay(tlx_s)
  );
  sla_div #(.NUM_W(TlNW), .DEN_W(RW), .Q_W(DirQW), .PAY_W(1)) u_div_tly (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .num(ny4_r), .den(dist4_r),
    .pay(sy4_r), .out_valid(tly_v), .quot(tly_q), .out_pay(tly_s)
  );
  sla_div #(.NUM_W(TlNW), .DEN_W(RW), .Q_W(DirQW), .PAY_W(1)) u_div_tlz (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .num(nz4_r), .den(dist4_r),
    .pay(sz4_r), .out_valid(tlz_v), .quot(tlz_q), .out_pay(tlz_s)
  );
  sla_div #(.NUM_W(CmNW), .DEN_W(RW), .Q_W(DirQW), .PAY_W(CmPW)) u_div_cm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .num(ncm4_r), .den(dist4_r),
    .pay({dist4_r, s4_r, deg4_r, dneg4_r}), .out_valid(cm_v), .quot(cm_q),
    .out_pay(cm_pay)
  );

  assign {c_dist, c_s, c_deg, c_dneg} = cm_pay;

  // stage 5: signed directions, cone classification, falloff numerator
  logic v5_r, deg5_r, low5_r, one5_r;
  logic signed [DirW-1:0] tlx5_r, tly5_r, tlz5_r;
  logic [DistW-1:0] dist5_r;
  logic [SW-1:0] s5_r;
  logic [FNumW-1:0] fnum5_r;
  logic [FDenW-1:0] fden5_r;
  logic signed [CW-1:0] c_val;
  logic signed [CosW-1:0] cos_hi, cos_lo;
  logic signed [CW:0] c_diff;
  logic [FDenW-1:0] f_den;
  logic c_low, c_one;

  always_comb begin
    c_val = c_dneg ? $signed({1'b0, cm_q}) : -$signed({1'b0, cm_q});
    cos_hi = (inner_cos_r < outer_cos_r) ? outer_cos_r : inner_cos_r;
    cos_lo = (inner_cos_r < outer_cos_r) ? inner_cos_r : outer_cos_r;
    c_low = c_val < CW'(cos_lo);
    c_one = (c_val > CW'(cos_hi)) || (cos_hi == cos_lo);
    c_diff = (CW + 1)'(c_val) - (CW + 1)'(cos_lo);
    f_den = FDenW'(FDenW'(cos_hi) - FDenW'(cos_lo));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= cm_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tlx5_r <= tlx_s ? -DirW'(tlx_q[FoW-1:0]) : DirW'(tlx_q[FoW-1:0]);
      tly5_r <= tly_s ? -DirW'(tly_q[FoW-1:0]) : DirW'(tly_q[FoW-1:0]);
      tlz5_r <= tlz_s ? -DirW'(tlz_q[FoW-1:0]) : DirW'(tlz_q[FoW-1:0]);
      dist5_r <= c_dist[RW-1] ? '1 : c_dist[DistW-1:0];
      s5_r <= c_s;
      deg5_r <= c_deg;
      low5_r <= c_low;
      one5_r <= c_one;
      if (!c_low && !c_one) begin
        fnum5_r <= FNumW'({c_diff[FDenW-1:0], {DirOneShift{1'b0}}}) + FNumW'(f_den >> 1);
        fden5_r <= f_den;
      end else begin
        fnum5_r <= '0;
        fden5_r <= FDenW'(1);
      end
    end
  end

  // falloff ratio divider
  logic dl_v;
  logic [FoW-1:0] dl_q;
  logic [DlPW-1:0] dl_pay;

  sla_div #(.NUM_W(FNumW), .DEN_W(FDenW), .Q_W(FoW), .PAY_W(DlPW)) u_div_fo (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_r), .num(fnum5_r), .den(fden5_r),
    .pay({tlx5_r, tly5_r, tlz5_r, dist5_r, s5_r, deg5_r, low5_r, one5_r}),
    .out_valid(dl_v), .quot(dl_q), .out_pay(dl_pay)
  );

  // stages 6 to 8: fourth power in two rounded squarings
  logic v6_r, v7_r, v8_r;
  logic [2*FoW-1:0] sq6_r, sq7_r;
  logic [DlPW-1:0] pay6_r, pay7_r;
  logic [DlPW-3:0] pay8_r;
  logic [FoW-1:0] fo8_r;
  logic [FoW-1:0] d2_nxt, d4_nxt;
  logic signed [DirW-1:0] f_tlx, f_tly, f_tlz;
  logic [DistW-1:0] f_dist;
  logic [SW-1:0] f_s, e_s;
  logic f_deg;
  logic [3*DirW+DistW-1:0] e_dir;
  logic e_deg, e_low, e_one;

  assign d2_nxt = FoW'((sq6_r + (2*FoW)'(1 << (DirOneShift - 1))) >> DirOneShift);
  assign d4_nxt = FoW'((sq7_r + (2*FoW)'(1 << (DirOneShift - 1))) >> DirOneShift);
  assign {e_dir, e_s, e_deg, e_low, e_one} = pay7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v6_r <= dl_v;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq6_r <= (2*FoW)'(dl_q) * (2*FoW)'(dl_q);
      pay6_r <= dl_pay;
      sq7_r <= (2*FoW)'(d2_nxt) * (2*FoW)'(d2_nxt);
      pay7_r <= pay6_r;
      if (e_low) fo8_r <= '0;
      else if (e_one) fo8_r <= FoW'(1 << DirOneShift);
      else fo8_r <= d4_nxt;
      pay8_r <= pay7_r[DlPW-1:2];
    end
  end

  assign {f_tlx, f_tly, f_tlz, f_dist, f_s, f_deg} = pay8_r;

  // stage 9: scaled falloff and saturation test
  logic v9_r, sat9_r, deg9_r;
  logic [AtNW-1:0] anum9_r;
  logic [SW-1:0] s9_r;
  logic signed [DirW-1:0] tlx9_r, tly9_r, tlz9_r;
  logic [DistW-1:0] dist9_r;
  logic [AtNW-1:0] anum_nxt;
  logic sat_nxt;

  always_comb begin
    anum_nxt = AtNW'(fo8_r) << Sh;
    sat_nxt = CmpW'(anum_nxt) >= CmpW'({f_s, {AttW{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      anum9_r <= sat_nxt ? '0 : anum_nxt;
      sat9_r <= sat_nxt;
      s9_r <= f_s;
      deg9_r <= f_deg;
      tlx9_r <= f_tlx;
      tly9_r <= f_tly;
      tlz9_r <= f_tlz;
      dist9_r <= f_dist;
    end
  end

  // attenuation divider
  logic at_v;
  logic [AttW-1:0] at_q;
  logic [AtPW-1:0] at_pay;
  logic signed [DirW-1:0] g_tlx, g_tly, g_tlz;
  logic [DistW-1:0] g_dist;
  logic g_deg, g_sat;

  sla_div #(.NUM_W(AtNW), .DEN_W(SW), .Q_W(AttW), .PAY_W(AtPW)) u_div_att (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v9_r), .num(anum9_r), .den(s9_r),
    .pay({tlx9_r, tly9_r, tlz9_r, dist9_r, deg9_r, sat9_r}),
    .out_valid(at_v), .quot(at_q), .out_pay(at_pay)
  );

  assign {g_tlx, g_tly, g_tlz, g_dist, g_deg, g_sat} = at_pay;

  // output word register
  logic signed [DirW-1:0] otlx_r, otly_r, otlz_r;
  logic [DistW-1:0] odist_r;
  logic [AttW-1:0] oatt_r;
  logic odeg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= at_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      otlx_r <= g_deg ? '0 : g_tlx;
      otly_r <= g_deg ? '0 : g_tly;
      otlz_r <= g_deg ? '0 : g_tlz;
      odist_r <= g_deg ? '0 : g_dist;
      oatt_r <= g_deg ? '0 : (g_sat ? '1 : at_q);
      odeg_r <= g_deg;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.to_light_x = otlx_r;
  assign out_ch.to_light_y = otly_r;
  assign out_ch.to_light_z = otlz_r;
  assign out_ch.light_distance = odist_r;
  assign out_ch.attenuation = oatt_r;
  assign out_ch.degenerate = odeg_r;

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (tlx_v == cm_v) && (tly_v == cm_v) && (tlz_v == cm_v))
    else $error("divider lanes out of step");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.attenuation == '0 && out_ch.light_distance == '0 &&
      out_ch.to_light_x == '0 && out_ch.to_light_y == '0 && out_ch.to_light_z == '0)
    else $error("degenerate word with nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.degenerate |->
      out_ch.to_light_x <= 18'sd65536 && out_ch.to_light_x >= -18'sd65536 &&
      out_ch.to_light_z <= 18'sd65536 && out_ch.to_light_z >= -18'sd65536)
    else $error("direction component out of unit range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && v1_r |=> v1_r)
    else $error("entry stage lost a word during stall");
endmodule

// ----- verif/tb_spot_light_attenuation.sv -----
// self-checking testbench for the spotlight cone falloff and inverse-square attenuation block
module tb_spot_light_attenuation;
  import sla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IdxW-1:0] IdxUnmapped = 4'd11;
  localparam int DrainCycles = 140;

  typedef struct {
    logic [DirW-1:0] tx;
    logic [DirW-1:0] ty;
    logic [DirW-1:0] tz;
    logic [DistW-1:0] distance;
    logic [AttW-1:0] att;
    logic degen;
  } light_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;

  logic signed [CoordW-1:0] lx, ly, lz;
  logic [CosW-1:0] ax, ay, az, icos, ocos;
  light_result_t pending_results[$];

  sla_in_if in_ch ();
  sla_out_if out_ch ();
  sla_cfg_if cfg_ch ();

  spot_light_attenuation DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint cone_falloff(longint c);
    longint ic, oc, t, num, den, dl, d2, d4;
    ic = longint'($signed(icos));
    oc = longint'($signed(ocos));
    if (ic < oc) begin
      t = ic;
      ic = oc;
      oc = t;
    end
    if (c < oc) return 0;
    if (c > ic || ic == oc) return 65536;
    num = c - oc;
    den = ic - oc;
    dl = ((num <<< 16) + den / 2) / den;
    d2 = (dl * dl + 32768) >>> 16;
    d4 = (d2 * d2 + 32768) >>> 16;
    return d4;
  endfunction

  function automatic light_result_t predict_light(logic signed [CoordW-1:0] px,
                                                  logic signed [CoordW-1:0] py,
                                                  logic signed [CoordW-1:0] pz);
    longint dv[3], av[3], dot, c;
    logic [127:0] mg[3], sq, root, cand, q, num, half;
    logic [63:0] fo;
    light_result_t r;
    dv[0] = longint'(lx) - longint'(px);
    dv[1] = longint'(ly) - longint'(py);
    dv[2] = longint'(lz) - longint'(pz);
    av[0] = longint'($signed(ax));
    av[1] = longint'($signed(ay));
    av[2] = longint'($signed(az));
    r = '{default: '0};
    if (dv[0] == 0 && dv[1] == 0 && dv[2] == 0) begin
      r.degen = 1'b1;
      return r;
    end
    sq = '0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = 128'(dv[i] < 0 ? -dv[i] : dv[i]);
      sq += mg[i] * mg[i];
      dot += dv[i] * av[i];
    end
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (128'(1) << b);
      if (cand * cand <= sq) root = cand;
    end
    half = root / 2;
    q = ((mg[0] << 16) + half) / root;
    r.tx = dv[0] < 0 ? DirW'(-q) : DirW'(q);
    q = ((mg[1] << 16) + half) / root;
    r.ty = dv[1] < 0 ? DirW'(-q) : DirW'(q);
    q = ((mg[2] << 16) + half) / root;
    r.tz = dv[2] < 0 ? DirW'(-q) : DirW'(q);
    r.distance = root > 128'hFFFF_FFFF ? '1 : root[31:0];
    q = (128'(dot < 0 ? -dot : dot) + half) / root;
    c = dot >= 0 ? -longint'(q) : longint'(q);
    fo = 64'(cone_falloff(c));
    num = 128'(fo) << (3 * CoordFracBitsDef - DirOneShift);
    q = num / sq;
    r.att = q > 128'hFFFF_FFFF ? '1 : q[31:0];
    return r;
  endfunction

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    light_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expected result");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.to_light_x !== e.tx) begin
          $error("to_light_x exp %0h got %0h", e.tx, out_ch.to_light_x); errors++;
        end
        if (out_ch.to_light_y !== e.ty) begin
          $error("to_light_y exp %0h got %0h", e.ty, out_ch.to_light_y); errors++;
        end
        if (out_ch.to_light_z !== e.tz) begin
          $error("to_light_z exp %0h got %0h", e.tz, out_ch.to_light_z); errors++;
        end
        if (out_ch.light_distance !== e.distance) begin
          $error("light_distance exp %0h got %0h", e.distance, out_ch.light_distance);
          errors++;
        end
        if (out_ch.attenuation !== e.att) begin
          $error("attenuation exp %0h got %0h", e.att, out_ch.attenuation); errors++;
        end
        if (out_ch.degenerate !== e.degen) begin
          $error("degenerate exp %0b got %0b", e.degen, out_ch.degenerate); errors++;
        end
      end
    end
  end

  task automatic send_point(logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
                            logic signed [CoordW-1:0] pz);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_light(px, py, pz));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LIGHT_X: lx = value;
      REG_LIGHT_Y: ly = value;
      REG_LIGHT_Z: lz = value;
      REG_AXIS_X: ax = value[CosW-1:0];
      REG_AXIS_Y: ay = value[CosW-1:0];
      REG_AXIS_Z: az = value[CosW-1:0];
      REG_INNER_COS: icos = value[CosW-1:0];
      REG_OUTER_COS: ocos = value[CosW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_light(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    cfg_write(REG_LIGHT_X, x);
    cfg_write(REG_LIGHT_Y, y);
    cfg_write(REG_LIGHT_Z, z);
  endtask

  task automatic set_cone(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [31:0] inner, logic [31:0] outer);
    cfg_write(REG_AXIS_X, x);
    cfg_write(REG_AXIS_Y, y);
    cfg_write(REG_AXIS_Z, z);
    cfg_write(REG_INNER_COS, inner);
    cfg_write(REG_OUTER_COS, outer);
  endtask

  task automatic test_reset_defaults();
    send_point(0, 0, 0);
    send_point(0, 0, 32'sd327680);
    send_point(0, 0, -32'sd327680);
    send_point(32'sd30000, 0, 32'sd65536);
    send_point(32'sd40000, 32'sd10000, 32'sd65536);
    send_point(1, 0, 0);
    drain();
  endtask

  task automatic test_extremes();
    set_light(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    set_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555);
    drain();
  endtask

  task automatic test_cone_cases();
    set_light(0, 0, 0);
    set_cone(0, 32'h3_0000, 0, 32'd52429, 32'd58982);
    send_point(0, 32'sd65536, 0);
    send_point(32'sd20000, 32'sd65536, 0);
    send_point(32'sd35000, 32'sd65536, 0);
    drain();
    set_cone(0, 32'h3_0000, 0, 32'd60000, 32'd60000);
    send_point(32'sd30000, 32'sd65536, 32'sd4);
    send_point(0, 32'sd65536, 0);
    drain();
    set_cone(32'h2_0000, 32'h1_FFFF, 32'h3_FFFF, 32'h2_0000, 32'h1_FFFF);
    send_point(32'sd1000, 32'sd2000, 32'sd3000);
    send_point(-32'sd1000, -32'sd2000, -32'sd3000);
    drain();
    cfg_write(IdxUnmapped, 32'hFFFF_FFFF);
    send_point(32'sd7, 32'sd9, -32'sd11);
    drain();
  endtask

  function automatic logic [31:0] pick_offset();
    logic [31:0] v;
    v = $urandom();
    return 32'($signed(v) >>> $urandom_range(31, 6));
  endfunction

  task automatic random_config();
    int sel;
    set_light($urandom() >>> $urandom_range(31, 0), $urandom(), $urandom() >>> 8);
    sel = $urandom_range(4);
    case (sel)
      0: set_cone(32'd65536, 0, 0, 32'd60000, 32'd40000);
      1: set_cone(0, 32'h3_0000, 0, 32'd65536, 32'h3_0000);
      2: set_cone(32'd37837, 32'd37837, 32'd37837, 32'd20000, 32'd50000);
      3: set_cone(0, 0, 32'd65536, 32'd45000, 32'd45000);
      default: set_cone($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endcase
  endtask

  task automatic test_random(int n_items, int s_idle, int r_idle);
    logic signed [CoordW-1:0] px, py, pz;
    longint t;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n_items; i++) begin
      if (i % 110 == 0) begin
        drain();
        random_config();
      end
      case ($urandom_range(9))
        0, 1, 2: begin
          px = $urandom();
          py = $urandom();
          pz = $urandom();
        end
        3, 4, 5: begin
          t = longint'($urandom_range(4000, 1));
          px = lx + 32'((longint'($signed(ax)) * t) >>> 4) + pick_offset();
          py = ly + 32'((longint'($signed(ay)) * t) >>> 4) + pick_offset();
          pz = lz + 32'((longint'($signed(az)) * t) >>> 4) + pick_offset();
        end
        6: begin
          px = lx;
          py = ly;
          pz = lz;
        end
        default: begin
          px = lx + pick_offset();
          py = ly + pick_offset();
          pz = lz + pick_offset();
        end
      endcase
      send_point(px, py, pz);
    end
    drain();
  endtask

  initial begin
    lx = '0;
    ly = '0;
    lz = '0;
    ax = AxisXRst;
    ay = AxisYRst;
    az = AxisZRst;
    icos = InnerCosRst;
    ocos = OuterCosRst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 36;
    recv_idle = 78;
    test_reset_defaults();
    test_extremes();
    test_cone_cases();
    test_random(550, 36, 78);
    test_random(550, 78, 36);
    test_random(550, 0, 0);
    if (errors == 0) begin
      $display("spot_light_attenuation regression: pass");
    end else begin
      $display("spot_light_attenuation regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("spot_light_attenuation regression: fail");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/sla_pkg.sv
rtl/sla_if.sv
rtl/sla_sqrt.sv
rtl/sla_div.sv
rtl/spot_light_attenuation.sv
verif/tb_spot_light_attenuation.sv
